// ===== design/bpmt_pkg.sv =====
// Breakpoint match table: shared types and codes.
// Request/response beat structs, controller/datapath command and status structs.
// No dependencies.
package bpmt_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [2:0] KIND_SW = 3'd0;

    localparam logic [1:0] ST_PASS        = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [1:0] ST_FULL        = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  bp_kind;
        logic [63:0] bp_addr;
        logic [31:0] bp_len;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic unsup;
        logic hit;
        logic last;
    } sts_t;

endpackage

// ===== design/bpmt_datapath.sv =====
// Breakpoint match table datapath: request register, slot memories, valid bits,
// scan read/compare stage and response register.
// Depends on bpmt_pkg.
module bpmt_datapath
    import bpmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_WIDTH  = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [1:0]            act_reg;
    logic [2:0]            kind_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [31:0]           len_reg;

    logic [ADDR_WIDTH-1:0] slot_addr_mem [TABLE_DEPTH];
    logic [31:0]           slot_len_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [ADDR_WIDTH-1:0] rd_addr_reg;
    logic [31:0]           rd_len_reg;

    logic [1:0] st_reg;
    logic [1:0] st_next;
    rsp_t       rsp_reg;

    logic vbit;
    logic addr_eq;
    logic len_eq;
    logic hit;
    logic unsup;
    logic set_en;
    logic clr_en;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= req.action;
            kind_reg <= req.bp_kind;
            addr_reg <= req.bp_addr[ADDR_WIDTH-1:0];
            len_reg  <= req.bp_len;
        end
    end

    // scan pointer and registered memory read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            rd_addr_reg <= slot_addr_mem[rd_idx_reg];
            rd_len_reg  <= slot_len_mem[rd_idx_reg];
            cmp_idx_reg <= rd_idx_reg;
            if (rd_idx_reg != LAST_IDX)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        vbit    = valid_reg[cmp_idx_reg];
        addr_eq = (rd_addr_reg == addr_reg);
        len_eq  = (rd_len_reg == len_reg);
        unsup   = (kind_reg != KIND_SW) || !(act_reg inside {ACT_INSERT, ACT_REMOVE, ACT_QUERY});
        case (act_reg)
            ACT_INSERT: hit = !vbit;
            ACT_REMOVE: hit = vbit && addr_eq && len_eq;
            ACT_QUERY:  hit = vbit && addr_eq;
            default:    hit = 1'b0;
        endcase

        if (unsup)
        begin
            st_next = ST_UNSUPPORTED;
        end
        else if (hit)
        begin
            st_next = ST_PASS;
        end
        else if (act_reg == ACT_INSERT)
        begin
            st_next = ST_FULL;
        end
        else
        begin
            st_next = ST_NOT_FOUND;
        end

        set_en = cmd.finish && !unsup && hit && (act_reg == ACT_INSERT);
        clr_en = cmd.finish && !unsup && hit && (act_reg == ACT_REMOVE);
    end

    always_ff @(posedge clk)
    begin
        if (set_en)
        begin
            slot_addr_mem[cmp_idx_reg] <= addr_reg;
            slot_len_mem[cmp_idx_reg]  <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (set_en)
        begin
            valid_reg[cmp_idx_reg] <= 1'b1;
        end
        else if (clr_en)
        begin
            valid_reg[cmp_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            st_reg <= st_next;
        end
        if (cmd.out_load)
        begin
            rsp_reg.ok     <= (st_reg == ST_PASS);
            rsp_reg.status <= st_reg;
        end
    end

    assign sts.unsup = unsup;
    assign sts.hit   = hit;
    assign sts.last  = (cmp_idx_reg == LAST_IDX);
    assign rsp       = rsp_reg;

endmodule

// ===== design/bpmt_ctrl.sv =====
// Breakpoint match table controller: handshake and scan sequencing.
// Drives cmd_t to the datapath, reads sts_t back. Depends on bpmt_pkg.
module bpmt_ctrl
    import bpmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.unsup)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/breakpoint_match_table_unit.sv =====
// Breakpoint match table top level: controller plus datapath.
// Depends on bpmt_pkg, bpmt_ctrl, bpmt_datapath.
//
// Request channel req/req_valid/req_ready carries one beat per operation:
// insert, remove (address and length must match) or query (address only),
// software kind only. Response channel rsp/rsp_valid/rsp_ready returns exactly
// one beat per request with ok and status.
// An unsupported kind or action is answered without a scan; any other request
// is answered once a slot decides the outcome or the whole table is scanned
// without a hit. The scan reads one slot per cycle from the slot memories and
// compares it in the following cycle. One request is in flight at a time;
// req_ready rises together with rsp_valid when the response is loaded, so no new
// request is accepted until the previous request's response has been loaded.
// If the receiver stalls, the response holds in its output register and the
// block accepts the next request; that request's result then waits until the
// held beat is taken.
// Reset empties the table (all valid bits clear) and drops any pending beat;
// the block is ready in the first cycle after reset.
module breakpoint_match_table_unit
    import bpmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_WIDTH  = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    bpmt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
